[rtl/core/fba_pkg.sv]
// Shared types, codes and helpers for the block allocator.
// Used by fba_free_map, fba_link_ram and fat_block_allocator_core.
package fba_pkg;

  localparam int WORD_W = 32;            // free-map word width
  localparam int BIT_W  = 5;             // bit select within a word
  localparam int IDX_W  = 16;            // internal block number width

  localparam logic [IDX_W-1:0] CHAIN_END = 16'hFFFF;

  // request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_EXTEND = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // position of the lowest set bit (zero when none is set)
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

[rtl/core/fba_free_map.sv]
// Free bitmap memory, one bit per block (1 = free), 32 blocks per word.
// Runs a clearing pass after reset; depends on fba_pkg.
module fba_free_map #(
  parameter int NUM_BLOCKS = 32768,
  parameter int DEPTH      = (NUM_BLOCKS + 31) / 32,
  parameter int WAW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WAW-1:0]     rd_addr,
  output fba_pkg::word_t     rd_data,
  input  logic               wr_en,
  input  logic [WAW-1:0]     wr_addr,
  input  fba_pkg::word_t     wr_data,
  output logic               ready
);
  import fba_pkg::*;

  localparam int LASTW    = (NUM_BLOCKS - 1) / WORD_W;
  localparam int LASTBITS = NUM_BLOCKS - LASTW * WORD_W;
  localparam word_t LAST_MASK = word_t'({WORD_W{1'b1}}) >> (WORD_W - LASTBITS);

  word_t mem [DEPTH];
  logic [WAW:0] clr_cnt_r;
  logic         clearing;
  word_t        clr_data;

  assign clearing = (clr_cnt_r < (WAW+1)'(DEPTH));
  assign ready    = !clearing;
  assign clr_data = (clr_cnt_r == (WAW+1)'(LASTW)) ? LAST_MASK : '1;

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[WAW-1:0]] <= clr_data;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/fba_link_ram.sv]
// Next-block link memory, 16 bits per block, registered read.
// Entries are written when a block is taken; depends on fba_pkg.
module fba_link_ram #(
  parameter int NUM_BLOCKS = 32768,
  parameter int LAW        = $clog2(NUM_BLOCKS)
) (
  input  logic                        clk,
  input  logic [fba_pkg::IDX_W-1:0]   rd_addr,
  output logic [fba_pkg::IDX_W-1:0]   rd_data,
  input  logic                        wr_en,
  input  logic [fba_pkg::IDX_W-1:0]   wr_addr,
  input  logic [fba_pkg::IDX_W-1:0]   wr_data
);
  import fba_pkg::*;

  logic [IDX_W-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[LAW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr[LAW-1:0]];
  end

endmodule

[rtl/core/fat_block_allocator_core.sv]
// Block allocator for a FAT-style store: request sequencer, config register,
// result register; free map and link memories. Depends on fba_pkg,
// fba_free_map and fba_link_ram.
//
// Usage: one request beat on in_* gives exactly one result beat on out_*.
// Start takes the first free block at or above first_usable_block; extend
// takes the first free block above a used tail and links the tail to it;
// free walks the chain from a used head and releases each block.
// One request is worked at a time. Start and extend scan the bitmap one
// 32-block word at a time (one free-map read, one check per word); extend
// first checks the tail and, once a block is found, writes the tail's link.
// Free does one free-map read and one check per block released; the
// registered bitmap read is why each step is a read and then a check.
// After reset the free map is swept, one word per cycle, with in_tready
// low; cfg writes are taken at any time.
// A finished result sits in an output register; the next request is taken
// while it waits, and a stalled receiver only holds the following result.
module fat_block_allocator_core #(
  parameter int NUM_BLOCKS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,      // first_usable_block
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,       // [1:0] req_type, [16:2] block_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata       // [1:0] status, [16:2] result_block,
                                      // [32:17] freed_count
);
  import fba_pkg::*;

  localparam int DEPTH = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [16:0] NB = 17'(NUM_BLOCKS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHKRD  = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_SCRD   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_LINK   = 4'd5;
  localparam logic [3:0] S_WALKRD = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [14:0]      fub_r;
  logic [1:0]       req_r, req_nxt;
  logic [14:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0] blk_r, blk_nxt;
  logic [WAW:0]     wptr_r, wptr_nxt;
  logic [BIT_W-1:0] low_r, low_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [14:0]      taken_r, taken_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [39:0]      out_data_r, out_data_nxt;

  logic             fm_ready, fm_we, lk_we;
  word_t            fm_rdata, fm_wdata, masked;
  logic [WAW-1:0]   fm_waddr;
  logic [IDX_W-1:0] lk_rdata, lk_waddr, lk_wdata, found_blk, start_ext, in_idx;
  logic [BIT_W-1:0] enc;
  logic [WAW:0]     wptr_inc;
  logic             accept;

  fba_free_map #(.NUM_BLOCKS(NUM_BLOCKS)) u_free_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (wptr_r[WAW-1:0]),
    .rd_data (fm_rdata),
    .wr_en   (fm_we),
    .wr_addr (fm_waddr),
    .wr_data (fm_wdata),
    .ready   (fm_ready)
  );

  fba_link_ram #(.NUM_BLOCKS(NUM_BLOCKS)) u_link_ram (
    .clk     (clk),
    .rd_addr (blk_r),
    .rd_data (lk_rdata),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata)
  );

  assign in_tready  = fm_ready && (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // scan helpers
  assign masked    = fm_rdata & (word_t'({WORD_W{1'b1}}) << low_r);
  assign enc       = lowest_set(masked);
  assign found_blk = IDX_W'({wptr_r[WAW-1:0], enc});
  assign wptr_inc  = wptr_r + 1'b1;
  assign in_idx    = IDX_W'(in_tdata[16:2]);
  assign start_ext = IDX_W'(idx_r) + 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fub_r <= 15'd39;
    end else if (cfg_we) begin
      fub_r <= cfg_wdata;
    end
  end

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    blk_nxt       = blk_r;
    wptr_nxt      = wptr_r;
    low_nxt       = low_r;
    cnt_nxt       = cnt_r;
    st_nxt        = st_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    fm_we         = 1'b0;
    fm_waddr      = wptr_r[WAW-1:0];
    fm_wdata      = fm_rdata;
    lk_we         = 1'b0;
    lk_waddr      = found_blk;
    lk_wdata      = CHAIN_END;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_tdata[1:0];
          idx_nxt   = in_tdata[16:2];
          st_nxt    = ST_OK;
          taken_nxt = '0;
          cnt_nxt   = '0;
          blk_nxt   = in_idx;
          wptr_nxt  = (WAW+1)'(in_idx[IDX_W-1:BIT_W]);
          priority case (in_tdata[1:0])
            REQ_START: begin
              if ({2'b0, fub_r} >= NB) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                wptr_nxt  = (WAW+1)'(fub_r[14:BIT_W]);
                low_nxt   = fub_r[BIT_W-1:0];
                state_nxt = S_SCRD;
              end
            end
            REQ_EXTEND, REQ_FREE: begin
              if ({2'b0, in_tdata[16:2]} >= NB) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                state_nxt = (in_tdata[1:0] == REQ_FREE) ? S_WALKRD : S_CHKRD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CHKRD: state_nxt = S_CHK;
      // tail must be in use, then scan from the block after it
      S_CHK: begin
        if (fm_rdata[blk_r[BIT_W-1:0]]) begin
          st_nxt    = ST_BAD;
          state_nxt = S_DONE;
        end else if ({1'b0, start_ext} >= NB) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          wptr_nxt  = (WAW+1)'(start_ext[IDX_W-1:BIT_W]);
          low_nxt   = start_ext[BIT_W-1:0];
          state_nxt = S_SCRD;
        end
      end
      S_SCRD: state_nxt = S_SCAN;
      // look for a free bit in the current word
      S_SCAN: begin
        if (|masked) begin
          fm_we     = 1'b1;
          fm_wdata  = fm_rdata & ~(word_t'(1) << enc);
          lk_we     = 1'b1;
          blk_nxt   = found_blk;
          taken_nxt = found_blk[14:0];
          state_nxt = (req_r == REQ_EXTEND) ? S_LINK : S_DONE;
        end else begin
          low_nxt  = '0;
          wptr_nxt = wptr_inc;
          if (wptr_inc == (WAW+1)'(DEPTH)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCRD;
          end
        end
      end
      // link the tail to the new block
      S_LINK: begin
        lk_we     = 1'b1;
        lk_waddr  = IDX_W'(idx_r);
        lk_wdata  = blk_r;
        state_nxt = S_DONE;
      end
      S_WALKRD: state_nxt = S_WALK;
      // release one block and follow its link
      S_WALK: begin
        if (fm_rdata[blk_r[BIT_W-1:0]]) begin
          if (cnt_r == '0) st_nxt = ST_BAD;
          state_nxt = S_DONE;
        end else begin
          fm_we    = 1'b1;
          fm_wdata = fm_rdata | (word_t'(1) << blk_r[BIT_W-1:0]);
          cnt_nxt  = cnt_r + 1'b1;
          if ({1'b0, lk_rdata} >= NB) begin
            state_nxt = S_DONE;
          end else begin
            blk_nxt   = lk_rdata;
            wptr_nxt  = (WAW+1)'(lk_rdata[IDX_W-1:BIT_W]);
            state_nxt = S_WALKRD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, cnt_r, taken_r, st_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    blk_r      <= blk_nxt;
    wptr_r     <= wptr_nxt;
    low_r      <= low_nxt;
    cnt_r      <= cnt_nxt;
    st_r       <= st_nxt;
    taken_r    <= taken_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
